FILE: hdl/iirl_pkg.sv
// shared types for the indexed insert/remove list
`timescale 1ns / 1ps

package iirl_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic   go;
      op_type op;
   } cmd_type;

endpackage

FILE: hdl/iirl_cell.sv
// one list slot: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps

module iirl_cell #(
   parameter int INDEX = 0,
   parameter int POS_W = 5
) (
   input  logic                                clock,
   input  iirl_pkg::cmd_type                   cmd,
   input  logic [POS_W-1:0]                    pos,
   input  logic [POS_W-1:0]                    count,
   input  logic signed [iirl_pkg::DATA_W-1:0]  new_value,
   input  logic signed [iirl_pkg::DATA_W-1:0]  left_value,
   input  logic signed [iirl_pkg::DATA_W-1:0]  right_value,
   input  logic [POS_W-1:0]                    rd_pos,
   input  logic                                rd_en,
   input  logic [POS_W-1:0]                    last_pos,
   input  logic                                last_en,
   output logic signed [iirl_pkg::DATA_W-1:0]  value,
   output logic signed [iirl_pkg::DATA_W-1:0]  rd_data,
   output logic signed [iirl_pkg::DATA_W-1:0]  last_data
);

   localparam logic [POS_W-1:0] IDX  = POS_W'(INDEX);
   localparam logic [POS_W-1:0] IDX1 = POS_W'(INDEX + 1);

   logic signed [iirl_pkg::DATA_W-1:0] value_ff;
   logic signed [iirl_pkg::DATA_W-1:0] value_in;
   logic                               load;

   always_comb begin
      load     = 1'b0;
      value_in = value_ff;
      case (cmd.op)
         iirl_pkg::OP_APPEND: begin
            if (IDX == count) begin
               load     = 1'b1;
               value_in = new_value;
            end
         end
         iirl_pkg::OP_INSERT: begin
            if (IDX == pos) begin
               load     = 1'b1;
               value_in = new_value;
            end else if (IDX > pos && IDX <= count) begin
               load     = 1'b1;
               value_in = left_value;
            end
         end
         iirl_pkg::OP_REMOVE: begin
            // close the gap: this slot and later ones, up to the one before the last entry, pull from the right
            if (IDX >= pos && IDX1 < count) begin
               load     = 1'b1;
               value_in = right_value;
            end
         end
         default: begin
            load     = 1'b0;
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.go && load) begin
         value_ff <= value_in;
      end
   end

   assign value     = value_ff;
   assign rd_data   = (rd_en && rd_pos == IDX) ? value_ff : '0;
   assign last_data = (last_en && last_pos == IDX) ? value_ff : '0;

endmodule

FILE: hdl/indexed_insert_remove_list_top.sv
// top level of the indexed insert/remove list (row of shifting cells)
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries, addressed by position.
// Each entry lives in its own cell; an insert makes each cell above the
// position, up to the count, take its left neighbor's entry, a remove makes
// each cell from the position up to the one before the last entry take its
// right neighbor's entry, all in the same clock edge.
// An item is taken whenever start is high and busy is low; busy stays low, so
// one item can be taken every cycle. The cells and the count are updated
// together with the first-stage registers; the second stage then registers
// the read value and the head and tail picked out of the cells, and raises
// rsp_valid for a single cycle per item; the receiver cannot stall.
// Reset clears the count and the valid flags; cells hold nothing meaningful
// until written, and no clearing pass is run.

module indexed_insert_remove_list_top #(
   parameter int DEPTH = 16,
   localparam int POS_W = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_op,
   input  logic [POS_W-1:0]                    req_position,
   input  logic signed [iirl_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic                                rsp_ok,
   output logic signed [iirl_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [POS_W-1:0]                    rsp_count,
   output logic signed [iirl_pkg::DATA_W-1:0]  rsp_head_value,
   output logic signed [iirl_pkg::DATA_W-1:0]  rsp_tail_value
);

   localparam logic [POS_W-1:0] FULL = POS_W'(DEPTH);

   // handshake: never stalls
   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   iirl_pkg::op_type op;
   assign op = iirl_pkg::op_type'(req_op);

   // count and decision for the item being taken
   logic [POS_W-1:0] count_ff;
   logic [POS_W-1:0] count_in;
   logic             ok;

   always_comb begin
      ok       = 1'b0;
      count_in = count_ff;
      case (op)
         iirl_pkg::OP_APPEND: begin
            ok = (count_ff != FULL);
            if (ok) count_in = count_ff + 1'b1;
         end
         iirl_pkg::OP_INSERT: begin
            ok = (count_ff != FULL) && (req_position <= count_ff);
            if (ok) count_in = count_ff + 1'b1;
         end
         iirl_pkg::OP_REMOVE: begin
            ok = (req_position < count_ff);
            if (ok) count_in = count_ff - 1'b1;
         end
         default: begin
            ok = (req_position < count_ff);
         end
      endcase
   end

   // command broadcast to the row of cells; refused items change nothing
   iirl_pkg::cmd_type cmd;
   assign cmd.go = accept && ok;
   assign cmd.op = op;

   // first stage: what the result still needs once the cells are updated
   logic             s1_valid_ff;
   logic             s1_ok_ff;
   logic             s1_read_ff;
   logic [POS_W-1:0] s1_pos_ff;
   logic [POS_W-1:0] s1_count_ff;
   logic [POS_W-1:0] s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ok_ff    <= ok;
         s1_read_ff  <= ok && (op == iirl_pkg::OP_READ);
         s1_pos_ff   <= req_position;
         s1_count_ff <= count_in;
         s1_last_ff  <= count_in - 1'b1;
      end
   end

   // the row of cells, each tied to its neighbors
   logic signed [iirl_pkg::DATA_W-1:0] cell_value [DEPTH];
   logic signed [iirl_pkg::DATA_W-1:0] cell_rd    [DEPTH];
   logic signed [iirl_pkg::DATA_W-1:0] cell_last  [DEPTH];
   logic                               list_nonempty;

   assign list_nonempty = (s1_count_ff != '0);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [iirl_pkg::DATA_W-1:0] left_v;
      logic signed [iirl_pkg::DATA_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_left
         assign left_v = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign right_v = '0;
      end else begin : g_right
         assign right_v = cell_value[i+1];
      end

      iirl_cell #(
         .INDEX (i),
         .POS_W (POS_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (req_position),
         .count       (count_ff),
         .new_value   (req_value),
         .left_value  (left_v),
         .right_value (right_v),
         .rd_pos      (s1_pos_ff),
         .rd_en       (s1_read_ff),
         .last_pos    (s1_last_ff),
         .last_en     (list_nonempty),
         .value       (cell_value[i]),
         .rd_data     (cell_rd[i]),
         .last_data   (cell_last[i])
      );
   end

   // at most one cell answers each select, so an or over the row picks it
   logic signed [iirl_pkg::DATA_W-1:0] rd_sel;
   logic signed [iirl_pkg::DATA_W-1:0] last_sel;

   always_comb begin
      rd_sel   = '0;
      last_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_sel   = rd_sel | cell_rd[i];
         last_sel = last_sel | cell_last[i];
      end
   end

   // second stage: result registers
   logic                               rsp_valid_ff;
   logic                               rsp_ok_ff;
   logic signed [iirl_pkg::DATA_W-1:0] rsp_read_ff;
   logic [POS_W-1:0]                   rsp_count_ff;
   logic signed [iirl_pkg::DATA_W-1:0] rsp_head_ff;
   logic signed [iirl_pkg::DATA_W-1:0] rsp_tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_ok_ff    <= s1_ok_ff;
         rsp_read_ff  <= rd_sel;
         rsp_count_ff <= s1_count_ff;
         rsp_head_ff  <= list_nonempty ? cell_value[0] : '0;
         rsp_tail_ff  <= last_sel;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_head_value = rsp_head_ff;
   assign rsp_tail_value = rsp_tail_ff;

   // checks on the list bookkeeping
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && op == iirl_pkg::OP_APPEND && count_ff != FULL)
         |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not grow the list");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("count beyond capacity");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count == '0) |-> (rsp_head_value == '0 && rsp_tail_value == '0))
      else $error("empty list shows nonzero head or tail");

   a_refused_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> rsp_read_value == '0)
      else $error("refused item returned read data");

   a_single_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count == POS_W'(1)) |-> rsp_head_value == rsp_tail_value)
      else $error("one-entry list has head and tail apart");

endmodule
